/* rtl/core/pscl_pkg.sv */
// Shared types, constants and helpers for the per-source connection limiter.
package pscl_pkg;

  // Slot table geometry
  localparam int PROCESSES           = 16;
  localparam int THREADS_PER_PROCESS = 16;
  localparam int SLOT_COUNT          = PROCESSES * THREADS_PER_PROCESS;
  localparam int SLOT_W              = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths
  localparam int ADDR_W  = 64;
  localparam int LIMIT_W = 16;
  localparam int OUT_W   = 9;
  localparam int PROC_W  = 4;
  localparam int THR_W   = 4;
  localparam int REG_W   = 2;

  // Per-category count carried down the chain, and the grown total
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int TOT_W = CNT_W + 2;
  localparam int CMP_W = (TOT_W > LIMIT_W) ? TOT_W : LIMIT_W;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Request types
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_TOTAL_LIMIT = 2'd0;
  localparam logic [REG_W-1:0] REG_READ_LIMIT  = 2'd1;
  localparam logic [REG_W-1:0] REG_WRITE_LIMIT = 2'd2;
  localparam logic [REG_W-1:0] REG_OTHER_LIMIT = 2'd3;

  // Reset values of the limits
  localparam logic [LIMIT_W-1:0] TOTAL_LIMIT_RST = 16'd30;
  localparam logic [LIMIT_W-1:0] CAT_LIMIT_RST   = 16'd10;

  // Slot state categories
  typedef enum logic [1:0] {
    CAT_IDLE  = 2'd0,
    CAT_READ  = 2'd1,
    CAT_WRITE = 2'd2,
    CAT_OTHER = 2'd3
  } cat_t;

  // Data written into one slot
  typedef struct packed {
    logic              set_state;
    cat_t              state;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
  } slot_data_t;

  // Slot write request from the controller
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_data_t        data;
  } slot_wr_t;

  // Probe that walks the chain, one cell per cycle
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] rd;
    logic [CNT_W-1:0] wr;
    logic [CNT_W-1:0] ot;
  } probe_t;

  // Clamp a count to the output width
  function automatic logic [OUT_W-1:0] sat_count(input logic [TOT_W-1:0] n);
    logic [OUT_W-1:0] res;
    if (n > TOT_W'(OUT_MAX)) begin
      res = OUT_MAX;
    end else begin
      res = OUT_W'(n);
    end
    return res;
  endfunction

  // Enabled limit reached
  function automatic logic limit_hit(input logic [LIMIT_W-1:0] limit,
                                     input logic [TOT_W-1:0]   count);
    return (limit != '0) && (CMP_W'(count) >= CMP_W'(limit));
  endfunction

endpackage

/* rtl/core/per_source_connection_limiter_unit.sv */
// Top level of the per-source connection limiter: control, limits and result register.
//
// Usage:
//   Items enter on start when busy is low. An update item (req_type 0) sets
//   one worker slot's category and address; a check item (req_type 1) stores
//   its address into its slot, then counts matching slots per category and
//   decides reject against the four limits. Slot numbers out of range write
//   nothing.
//   Each item yields one result, shown for one cycle with out_valid high.
//   Updates and exempt checks answer with zeros in the cycle after acceptance.
//   A non-exempt check sends a probe down the row of 256 slot cells, one cell
//   per cycle; its result is registered once the probe leaves the last cell.
//   busy stays high until the result is shown, so the next item is taken
//   in the cycle the result is shown; an update or exempt check never raises busy.
//   Limits are written through cfg_valid/cfg_ready (always ready) by index:
//   0 total, 1 read, 2 write, 3 other; 0 disables a limit. Write them only
//   while no item is in flight.
//   Reset (synchronous, rst_n low) clears every slot to idle with address
//   zero and restores limits 30/10/10/10. The receiver cannot stall: results
//   must be taken in the cycle they are shown.
module per_source_connection_limiter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [pscl_pkg::PROC_W-1:0]   in_process_num,
  input  logic [pscl_pkg::THR_W-1:0]    in_worker_num,
  input  logic [1:0]                    in_slot_category,
  input  logic [pscl_pkg::ADDR_W-1:0]   in_addr_high,
  input  logic [pscl_pkg::ADDR_W-1:0]   in_addr_low,
  input  logic                          in_exempt,
  output logic                          out_valid,
  output logic                          out_reject,
  output logic [pscl_pkg::OUT_W-1:0]    out_read_count,
  output logic [pscl_pkg::OUT_W-1:0]    out_write_count,
  output logic [pscl_pkg::OUT_W-1:0]    out_other_count,
  output logic [pscl_pkg::OUT_W-1:0]    out_total_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pscl_pkg::REG_W-1:0]    cfg_index,
  input  logic [pscl_pkg::LIMIT_W-1:0]  cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                         state_r;
  logic                           launch_r;
  logic [pscl_pkg::ADDR_W-1:0]    key_high_r;
  logic [pscl_pkg::ADDR_W-1:0]    key_low_r;
  logic                           out_valid_r;
  logic                           out_reject_r;
  logic [pscl_pkg::OUT_W-1:0]     out_rd_r;
  logic [pscl_pkg::OUT_W-1:0]     out_wr_r;
  logic [pscl_pkg::OUT_W-1:0]     out_ot_r;
  logic [pscl_pkg::OUT_W-1:0]     out_tot_r;
  logic [pscl_pkg::LIMIT_W-1:0]   total_limit_r;
  logic [pscl_pkg::LIMIT_W-1:0]   read_limit_r;
  logic [pscl_pkg::LIMIT_W-1:0]   write_limit_r;
  logic [pscl_pkg::LIMIT_W-1:0]   other_limit_r;

  logic                           accept;
  logic                           slot_ok;
  logic                           scan_req;
  pscl_pkg::slot_wr_t             slot_wr;
  pscl_pkg::probe_t               probe_head;
  pscl_pkg::probe_t               probe_tail;
  logic [pscl_pkg::TOT_W-1:0]     cnt_rd;
  logic [pscl_pkg::TOT_W-1:0]     cnt_wr;
  logic [pscl_pkg::TOT_W-1:0]     cnt_ot;
  logic [pscl_pkg::TOT_W-1:0]     cnt_tot;
  logic                           reject_nxt;

  assign busy      = (state_r == ST_SCAN);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Slot address decode
  assign slot_ok = (int'(in_process_num) < pscl_pkg::PROCESSES) &&
                   (int'(in_worker_num) < pscl_pkg::THREADS_PER_PROCESS);

  always_comb begin
    slot_wr.en                  = accept && slot_ok;
    slot_wr.idx                 = pscl_pkg::SLOT_W'(
                                    pscl_pkg::SLOT_W'(in_process_num) *
                                    pscl_pkg::SLOT_W'(pscl_pkg::THREADS_PER_PROCESS)
                                    + pscl_pkg::SLOT_W'(in_worker_num));
    slot_wr.data.set_state      = (in_req_type == pscl_pkg::REQ_UPDATE);
    slot_wr.data.state          = pscl_pkg::cat_t'(in_slot_category);
    slot_wr.data.addr_high      = in_addr_high;
    slot_wr.data.addr_low       = in_addr_low;
  end

  assign scan_req = accept && (in_req_type == pscl_pkg::REQ_CHECK) && !in_exempt;

  // Fresh probe enters the first cell the cycle after the slot write
  always_comb begin
    probe_head.valid = launch_r;
    probe_head.rd    = '0;
    probe_head.wr    = '0;
    probe_head.ot    = '0;
  end

  pscl_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .slot_wr  (slot_wr),
    .key_high (key_high_r),
    .key_low  (key_low_r),
    .probe_in (probe_head),
    .probe_out(probe_tail)
  );

  // Decision on the counts leaving the last cell
  assign cnt_rd  = pscl_pkg::TOT_W'(probe_tail.rd);
  assign cnt_wr  = pscl_pkg::TOT_W'(probe_tail.wr);
  assign cnt_ot  = pscl_pkg::TOT_W'(probe_tail.ot);
  assign cnt_tot = cnt_rd + cnt_wr + cnt_ot;

  assign reject_nxt = pscl_pkg::limit_hit(total_limit_r, cnt_tot) ||
                      pscl_pkg::limit_hit(read_limit_r,  cnt_rd)  ||
                      pscl_pkg::limit_hit(write_limit_r, cnt_wr)  ||
                      pscl_pkg::limit_hit(other_limit_r, cnt_ot);

  // Control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r    <= scan_req;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (scan_req) begin
            state_r <= ST_SCAN;
          end else if (accept) begin
            out_valid_r <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (probe_tail.valid) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (scan_req) begin
      key_high_r <= in_addr_high;
      key_low_r  <= in_addr_low;
    end
    if (busy && probe_tail.valid) begin
      out_reject_r <= reject_nxt;
      out_rd_r     <= pscl_pkg::sat_count(cnt_rd);
      out_wr_r     <= pscl_pkg::sat_count(cnt_wr);
      out_ot_r     <= pscl_pkg::sat_count(cnt_ot);
      out_tot_r    <= pscl_pkg::sat_count(cnt_tot);
    end else if (accept) begin
      out_reject_r <= 1'b0;
      out_rd_r     <= '0;
      out_wr_r     <= '0;
      out_ot_r     <= '0;
      out_tot_r    <= '0;
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_limit_r <= pscl_pkg::TOTAL_LIMIT_RST;
      read_limit_r  <= pscl_pkg::CAT_LIMIT_RST;
      write_limit_r <= pscl_pkg::CAT_LIMIT_RST;
      other_limit_r <= pscl_pkg::CAT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pscl_pkg::REG_TOTAL_LIMIT: total_limit_r <= cfg_data;
        pscl_pkg::REG_READ_LIMIT:  read_limit_r  <= cfg_data;
        pscl_pkg::REG_WRITE_LIMIT: write_limit_r <= cfg_data;
        pscl_pkg::REG_OTHER_LIMIT: other_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reject      = out_reject_r;
  assign out_read_count  = out_rd_r;
  assign out_write_count = out_wr_r;
  assign out_other_count = out_ot_r;
  assign out_total_count = out_tot_r;

  // Checks

  // A non-exempt check holds the block busy while its probe walks
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    scan_req |=> busy)
    else $error("check item did not start a scan");

  // The probe reaching the end of the row always produces a result
  a_tail_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && probe_tail.valid) |=> (out_valid && !busy))
    else $error("finished scan gave no result");

  // Only one probe is ever in the row, so none leaves while idle
  a_no_stray_probe: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !probe_tail.valid)
    else $error("probe left the row while idle");

  // Total never falls below any category count
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_count >= out_read_count &&
                   out_total_count >= out_write_count &&
                   out_total_count >= out_other_count))
    else $error("total count below a category count");

endmodule

/* rtl/core/pscl_cell.sv */
// One worker slot: holds category and address, adds its match to the passing probe.
module pscl_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  pscl_pkg::slot_data_t        wr_data,
  input  logic [pscl_pkg::ADDR_W-1:0] key_high,
  input  logic [pscl_pkg::ADDR_W-1:0] key_low,
  input  pscl_pkg::probe_t            probe_in,
  output pscl_pkg::probe_t            probe_out
);

  pscl_pkg::cat_t              state_r;
  logic [pscl_pkg::ADDR_W-1:0] addr_high_r;
  logic [pscl_pkg::ADDR_W-1:0] addr_low_r;
  pscl_pkg::probe_t            probe_r;
  logic                        hit;

  // Slot contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pscl_pkg::CAT_IDLE;
      addr_high_r <= '0;
      addr_low_r  <= '0;
    end else if (wr_en) begin
      addr_high_r <= wr_data.addr_high;
      addr_low_r  <= wr_data.addr_low;
      if (wr_data.set_state) begin
        state_r <= wr_data.state;
      end
    end
  end

  assign hit = (addr_high_r == key_high) && (addr_low_r == key_low);

  // Probe stage: pass on, bumping the count of this slot's category on a match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_in.valid;
    end
    probe_r.rd <= probe_in.rd + pscl_pkg::CNT_W'(hit && (state_r == pscl_pkg::CAT_READ));
    probe_r.wr <= probe_in.wr + pscl_pkg::CNT_W'(hit && (state_r == pscl_pkg::CAT_WRITE));
    probe_r.ot <= probe_in.ot + pscl_pkg::CNT_W'(hit && (state_r == pscl_pkg::CAT_OTHER));
  end

  assign probe_out = probe_r;

endmodule

/* rtl/core/pscl_chain.sv */
// Row of slot cells: write decode per cell and the probe path through all of them.
module pscl_chain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pscl_pkg::slot_wr_t          slot_wr,
  input  logic [pscl_pkg::ADDR_W-1:0] key_high,
  input  logic [pscl_pkg::ADDR_W-1:0] key_low,
  input  pscl_pkg::probe_t            probe_in,
  output pscl_pkg::probe_t            probe_out
);

  pscl_pkg::probe_t link [pscl_pkg::SLOT_COUNT+1];

  assign link[0] = probe_in;

  // One cell per slot, probe handed from cell k to cell k+1
  for (genvar k = 0; k < pscl_pkg::SLOT_COUNT; k++) begin : g_cell
    logic wr_en;
    assign wr_en = slot_wr.en && (slot_wr.idx == pscl_pkg::SLOT_W'(k));

    pscl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en),
      .wr_data  (slot_wr.data),
      .key_high (key_high),
      .key_low  (key_low),
      .probe_in (link[k]),
      .probe_out(link[k+1])
    );
  end

  assign probe_out = link[pscl_pkg::SLOT_COUNT];

endmodule

/* verif/per_source_connection_limiter_unit_tb.sv */
// Self-checking testbench for the per-source connection limiter: slot table, counts, limits.
module per_source_connection_limiter_unit_tb;
  import pscl_pkg::*;

  localparam int RANDOM_ITEMS   = 1330;
  localparam int LIMIT_PHASES   = 10;
  localparam int POOL_SIZE      = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 4_000_000;

  // Slot table mirror, limit registers and queue of expected verdicts
  class conn_limit_scoreboard;
    typedef struct packed {
      logic             reject;
      logic [OUT_W-1:0] rd;
      logic [OUT_W-1:0] wr;
      logic [OUT_W-1:0] ot;
      logic [OUT_W-1:0] tot;
    } verdict_t;

    cat_t               slot_cat [SLOT_COUNT];
    logic [ADDR_W-1:0]  slot_hi  [SLOT_COUNT];
    logic [ADDR_W-1:0]  slot_lo  [SLOT_COUNT];
    logic [LIMIT_W-1:0] lim_total, lim_read, lim_write, lim_other;
    verdict_t           pending_verdicts [$];
    int                 errors, n_updates, n_checks, n_exempt, n_rejects;

    function new();
      foreach (slot_cat[k]) begin
        slot_cat[k] = CAT_IDLE;
        slot_hi[k]  = '0;
        slot_lo[k]  = '0;
      end
      lim_total = TOTAL_LIMIT_RST;
      lim_read  = CAT_LIMIT_RST;
      lim_write = CAT_LIMIT_RST;
      lim_other = CAT_LIMIT_RST;
      errors    = 0;
      n_updates = 0;
      n_checks  = 0;
      n_exempt  = 0;
      n_rejects = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endfunction

    function void set_limit(logic [REG_W-1:0] idx, logic [LIMIT_W-1:0] val);
      case (idx)
        REG_TOTAL_LIMIT: lim_total = val;
        REG_READ_LIMIT:  lim_read  = val;
        REG_WRITE_LIMIT: lim_write = val;
        REG_OTHER_LIMIT: lim_other = val;
        default: ;
      endcase
    endfunction

    // Zero limit is disabled
    function bit trips(logic [LIMIT_W-1:0] lim, int cnt);
      return (lim != '0) && (cnt >= int'(lim));
    endfunction

    function logic [OUT_W-1:0] clamp(int cnt);
      return (cnt > int'(OUT_MAX)) ? OUT_MAX : OUT_W'(cnt);
    endfunction

    // Apply one accepted item to the mirror and queue its verdict
    function void note_item(logic req, logic [PROC_W-1:0] pn, logic [THR_W-1:0] wn,
                            logic [1:0] cat, logic [ADDR_W-1:0] ah,
                            logic [ADDR_W-1:0] al, logic ex);
      verdict_t v;
      bit       in_range;
      int       idx, n_rd, n_wr, n_ot;
      v        = '0;
      in_range = (int'(pn) < PROCESSES) && (int'(wn) < THREADS_PER_PROCESS);
      idx      = int'(pn) * THREADS_PER_PROCESS + int'(wn);
      if (req == REQ_UPDATE) begin
        n_updates++;
        if (in_range) begin
          slot_cat[idx] = cat_t'(cat);
          slot_hi[idx]  = ah;
          slot_lo[idx]  = al;
        end
      end else begin
        n_checks++;
        // check stores its address first, category untouched
        if (in_range) begin
          slot_hi[idx] = ah;
          slot_lo[idx] = al;
        end
        if (ex) begin
          n_exempt++;
        end else begin
          n_rd = 0;
          n_wr = 0;
          n_ot = 0;
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (slot_hi[k] == ah && slot_lo[k] == al) begin
              case (slot_cat[k])
                CAT_READ:  n_rd++;
                CAT_WRITE: n_wr++;
                CAT_OTHER: n_ot++;
                default: ;
              endcase
            end
          end
          v.reject = trips(lim_total, n_rd + n_wr + n_ot) || trips(lim_read, n_rd) ||
                     trips(lim_write, n_wr) || trips(lim_other, n_ot);
          v.rd  = clamp(n_rd);
          v.wr  = clamp(n_wr);
          v.ot  = clamp(n_ot);
          v.tot = clamp(n_rd + n_wr + n_ot);
          if (v.reject) n_rejects++;
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic rej, logic [OUT_W-1:0] rd, logic [OUT_W-1:0] wr,
                               logic [OUT_W-1:0] ot, logic [OUT_W-1:0] tot);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result with no item pending: reject=%0b total=%0d", rej, tot));
        return;
      end
      v = pending_verdicts.pop_front();
      if (rej !== v.reject) report($sformatf("reject got %0b want %0b", rej, v.reject));
      if (rd !== v.rd)      report($sformatf("read_count got %0d want %0d", rd, v.rd));
      if (wr !== v.wr)      report($sformatf("write_count got %0d want %0d", wr, v.wr));
      if (ot !== v.ot)      report($sformatf("other_count got %0d want %0d", ot, v.ot));
      if (tot !== v.tot)    report($sformatf("total_count got %0d want %0d", tot, v.tot));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_req_type;
  logic [PROC_W-1:0] in_process_num;
  logic [THR_W-1:0]  in_worker_num;
  logic [1:0]        in_slot_category;
  logic [ADDR_W-1:0] in_addr_high;
  logic [ADDR_W-1:0] in_addr_low;
  logic              in_exempt;
  logic              out_valid;
  logic              out_reject;
  logic [OUT_W-1:0]  out_read_count;
  logic [OUT_W-1:0]  out_write_count;
  logic [OUT_W-1:0]  out_other_count;
  logic [OUT_W-1:0]  out_total_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [REG_W-1:0]  cfg_index;
  logic [LIMIT_W-1:0] cfg_data;

  conn_limit_scoreboard sb;
  logic [127:0] addr_pool [POOL_SIZE];

  per_source_connection_limiter_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_process_num  (in_process_num),
    .in_worker_num   (in_worker_num),
    .in_slot_category(in_slot_category),
    .in_addr_high    (in_addr_high),
    .in_addr_low     (in_addr_low),
    .in_exempt       (in_exempt),
    .out_valid       (out_valid),
    .out_reject      (out_reject),
    .out_read_count  (out_read_count),
    .out_write_count (out_write_count),
    .out_other_count (out_other_count),
    .out_total_count (out_total_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: note accepted items, check results, all on the pre-edge values
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) begin
        sb.note_item(in_req_type, in_process_num, in_worker_num, in_slot_category,
                     in_addr_high, in_addr_low, in_exempt);
      end
      if (out_valid === 1'b1) begin
        sb.check_result(out_reject, out_read_count, out_write_count, out_other_count,
                        out_total_count);
      end
    end
  end

  // Present one item and hold it until the block takes it
  task automatic drive_item(logic req, logic [PROC_W-1:0] pn, logic [THR_W-1:0] wn,
                            logic [1:0] cat, logic [ADDR_W-1:0] ah,
                            logic [ADDR_W-1:0] al, logic ex);
    start            <= 1'b1;
    in_req_type      <= req;
    in_process_num   <= pn;
    in_worker_num    <= wn;
    in_slot_category <= cat;
    in_addr_high     <= ah;
    in_addr_low      <= al;
    in_exempt        <= ex;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every expected verdict has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_limits(logic [LIMIT_W-1:0] l_total, logic [LIMIT_W-1:0] l_read,
                              logic [LIMIT_W-1:0] l_write, logic [LIMIT_W-1:0] l_other);
    logic [LIMIT_W-1:0] vals [4];
    logic [REG_W-1:0]   regs [4];
    vals[0] = l_total;  regs[0] = REG_TOTAL_LIMIT;
    vals[1] = l_read;   regs[1] = REG_READ_LIMIT;
    vals[2] = l_write;  regs[2] = REG_WRITE_LIMIT;
    vals[3] = l_other;  regs[3] = REG_OTHER_LIMIT;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_limit(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LIMIT_W-1:0] rand_limit(int hi);
    return ($urandom_range(0, 5) == 0) ? '0 : LIMIT_W'($urandom_range(1, hi));
  endfunction

  // Mostly a hot address or the shared pool so counts climb; some scattered noise
  function automatic logic [127:0] pick_addr(int hot);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      return addr_pool[hot];
    else if (r < 80) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 90) return {96'd0, 32'($urandom)};
    else             return {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
  endfunction

  task automatic send_random_item(int hot);
    logic [127:0] a;
    logic         req;
    a   = pick_addr(hot);
    req = ($urandom_range(0, 99) < 35) ? REQ_CHECK : REQ_UPDATE;
    drive_item(req, PROC_W'($urandom), THR_W'($urandom), 2'($urandom), a[127:64], a[63:0],
               ($urandom_range(0, 6) == 0));
  endtask

  task automatic run_directed();
    logic [127:0] a, b;
    a = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
    b = ~a;
    // empty table: address zero matches every slot but all are idle
    drive_item(REQ_CHECK, '0, '0, CAT_IDLE, '0, '0, 1'b0);
    // one slot per category, corner slots among them; idle is never counted
    drive_item(REQ_UPDATE, 4'd0, 4'd0, CAT_READ, a[127:64], a[63:0], 1'b0);
    drive_item(REQ_UPDATE, 4'd15, 4'd15, CAT_WRITE, a[127:64], a[63:0], 1'b0);
    drive_item(REQ_UPDATE, 4'd3, 4'd7, CAT_OTHER, a[127:64], a[63:0], 1'b0);
    drive_item(REQ_UPDATE, 4'd1, 4'd1, CAT_IDLE, a[127:64], a[63:0], 1'b0);
    drive_item(REQ_CHECK, 4'd2, 4'd2, CAT_IDLE, a[127:64], a[63:0], 1'b0);
    // exempt check answers zeros
    drive_item(REQ_CHECK, 4'd15, 4'd15, CAT_OTHER, a[127:64], a[63:0], 1'b1);
    // ten readers on the all-ones address hit the read limit
    for (int i = 0; i < 10; i++) begin
      drive_item(REQ_UPDATE, 4'd8, THR_W'(i), CAT_READ, '1, '1, 1'b0);
    end
    drive_item(REQ_CHECK, 4'd9, 4'd0, CAT_READ, '1, '1, 1'b0);
    drive_item(REQ_CHECK, 4'd9, 4'd1, CAT_READ, '1, '1, 1'b1);
    // a check moves a counted slot to a new address, its category stays
    drive_item(REQ_CHECK, 4'd0, 4'd0, CAT_WRITE, b[127:64], b[63:0], 1'b0);
    drive_item(REQ_CHECK, 4'd2, 4'd3, CAT_IDLE, a[127:64], a[63:0], 1'b0);
    drain();
  endtask

  initial begin
    int per_phase, sent, burst, hot, r;
    bit no_gaps;
    sb = new();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = {96'd0, 32'($urandom)};
    for (int i = 3; i < POOL_SIZE; i++) begin
      addr_pool[i] = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
    end
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_req_type      <= REQ_UPDATE;
    in_process_num   <= '0;
    in_worker_num    <= '0;
    in_slot_category <= CAT_IDLE;
    in_addr_high     <= '0;
    in_addr_low      <= '0;
    in_exempt        <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_TOTAL_LIMIT;
    cfg_data         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // random traffic under a series of limit settings
    per_phase = RANDOM_ITEMS / LIMIT_PHASES;
    for (int ph = 0; ph < LIMIT_PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_limits(16'd1, 16'd1, 16'd1, 16'd1);
        1: apply_limits('1, '1, '1, '1);
        2: apply_limits('0, '0, '0, '0);
        3: apply_limits(TOTAL_LIMIT_RST, CAT_LIMIT_RST, CAT_LIMIT_RST, CAT_LIMIT_RST);
        4: apply_limits('0, rand_limit(25), rand_limit(25), rand_limit(25));
        default: apply_limits(rand_limit(60), rand_limit(25), rand_limit(25),
                              rand_limit(25));
      endcase
      hot     = $urandom_range(0, POOL_SIZE - 1);
      no_gaps = (ph % 3 == 1);
      sent    = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 16);
        for (int i = 0; i < burst && sent < per_phase; i++) begin
          send_random_item(hot);
          sent++;
        end
        if (!no_gaps) begin
          r = $urandom_range(0, 99);
          // long gaps land anywhere in a check's walk
          if (r < 25)      ;
          else if (r < 30) drain();
          else if (r < 40) pause_sender($urandom_range(20, 300));
          else             pause_sender($urandom_range(1, 12));
        end
      end
    end

    drain();
    if (sb.pending_verdicts.size() != 0) begin
      sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));
    end
    $display("Covered %0d updates and %0d checks (%0d exempt, %0d rejected)",
             sb.n_updates, sb.n_checks, sb.n_exempt, sb.n_rejects);
    $display("across %0d limit settings, extremes 0, 1 and 65535 included.",
             LIMIT_PHASES + 1);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd10 * TIMEOUT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
